### hdl/ggps_pkg.sv
// ----------------------------------------------------------------------------
// ggps_pkg
// Shared types, codes and helpers for the greedy grid path step block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ggps_pkg;

  // path cost store width and saturation value
  localparam int COST_W   = 24;
  localparam int COST_MAX = 16777215;

  // default sizes
  localparam int MAX_COLS_DEF  = 256;
  localparam int MAX_ROWS_DEF  = 256;
  localparam int FRAC_BITS_DEF = 8;

  // register reset values
  localparam logic [8:0] COLS_RST         = 9'd255;
  localparam logic [8:0] ROWS_RST         = 9'd256;
  localparam logic [7:0] GOAL_FORWARD_RST = 8'd12;
  localparam logic [7:0] GOAL_LATERAL_RST = 8'd0;

  // operation codes carried on tuser
  typedef enum logic [1:0] {
    OP_BLOCK   = 2'd0,
    OP_STEP    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // register indexes (word address)
  typedef enum logic [1:0] {
    REG_COLS         = 2'd0,
    REG_ROWS         = 2'd1,
    REG_GOAL_FORWARD = 2'd2,
    REG_GOAL_LATERAL = 2'd3
  } reg_idx_t;

  // neighbour column offset, fixed search order
  function automatic logic signed [1:0] nb_dc(input logic [2:0] i);
    logic signed [1:0] d;
    unique case (i)
      3'd0, 3'd1, 3'd7: d = -2'sd1;
      3'd2, 3'd6:       d = 2'sd0;
      default:          d = 2'sd1;
    endcase
    return d;
  endfunction

  // neighbour row offset, fixed search order
  function automatic logic signed [1:0] nb_dr(input logic [2:0] i);
    logic signed [1:0] d;
    unique case (i)
      3'd0, 3'd4:       d = 2'sd0;
      3'd1, 3'd2, 3'd3: d = 2'sd1;
      default:          d = -2'sd1;
    endcase
    return d;
  endfunction

  // floor square root, elaboration-time use only
  function automatic longint unsigned isqrt_const(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int k = 31; k >= 0; k--) begin
      t = r | (longint'(1) << k);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/ggps_ram.sv
// ----------------------------------------------------------------------------
// ggps_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ggps_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### hdl/ggps_isqrt.sv
// ----------------------------------------------------------------------------
// ggps_isqrt
// Bit-serial floor square root, one root bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ggps_isqrt #(
  parameter int RAD_W = 38
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [RAD_W-1:0]   radicand,
  output logic                    busy,
  output logic                    done,
  output logic      [RAD_W/2-1:0] root
);

  localparam int RW  = RAD_W / 2;
  localparam int CW  = $clog2(RW + 1);

  logic [RAD_W-1:0] rad;
  logic [RW+1:0]    rem;
  logic [CW-1:0]    cnt;
  logic [RW+1:0]    rem_sh;
  logic [RW+1:0]    trial;

  // trial subtract of the next pair of bits
  assign rem_sh = {rem[RW-1:0], rad[RAD_W-1 -: 2]};
  assign trial  = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= CW'(RW);
      end else if (busy) begin
        rad <= {rad[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[RW-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[RW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### hdl/greedy_grid_path_step.sv
// ----------------------------------------------------------------------------
// greedy_grid_path_step
// Greedy best-first walker on an 8-connected grid held in one RAM.
// ----------------------------------------------------------------------------
//  channel   direction  beat contents
//  s_*       in         tuser: op; tdata: cell_col, cell_row
//  m_*       out        tdata: pos_lateral, pos_forward, path_cost, arrived,
//                       dead_end
//  apb       in/out     column count, row count, goal_forward, goal_lateral
//
//  Block: read the cell, then set its closed mark. Restart and reset: a
//  clearing pass over all MAX_COLS*MAX_ROWS cells (65536 by default) of
//  the grid RAM, no beat taken meanwhile. Step: accept, fetch, then per
//  open in-bounds neighbour a square, a bit-serial root of RW bits with
//  RW = FRAC_BITS + max(address bits, 8) + 3 (19 by default) and an
//  evaluation, skipping blocked and off-grid ones; then update and output.
//  A held result stalls only the next step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module greedy_grid_path_step #(
  parameter int MAX_COLS  = ggps_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS  = ggps_pkg::MAX_ROWS_DEF,
  parameter int FRAC_BITS = ggps_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [7:0] cell_col, [15:8] cell_row
  input  wire logic [1:0]  s_tuser,   // [1:0] op
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [47:0] m_tdata,   // [7:0] pos_lateral, [15:8] pos_forward,
                                      // [39:16] path_cost, [40] arrived,
                                      // [41] dead_end, [47:42] zero
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  import ggps_pkg::*;

  localparam int COL_W  = $clog2(MAX_COLS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int CELLS  = MAX_COLS * MAX_ROWS;
  localparam int AW     = $clog2(CELLS);
  localparam int BIG_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int SW     = ((BIG_W > 8) ? BIG_W : 8) + 3;
  localparam int MW     = SW - 1;
  localparam int SQ_W   = 2 * MW + 1;
  localparam int RAD_W  = 2 * MW + 2 + 2 * FRAC_BITS;
  localparam int RW     = RAD_W / 2;
  localparam int FW     = ((RW > COST_W) ? RW : COST_W) + 1;
  localparam int UW     = ((BIG_W + 1) > 9) ? (BIG_W + 1) : 9;
  localparam int DW     = COST_W + 1;
  localparam logic [COST_W-1:0] STEP_ONE  = COST_W'(longint'(1) << FRAC_BITS);
  localparam logic [COST_W-1:0] STEP_DIAG =
    COST_W'(isqrt_const(longint'(2) << (2 * FRAC_BITS)));
  localparam int RST_W    = (COLS_RST > MAX_COLS) ? MAX_COLS : COLS_RST;
  localparam int RST_HALF = RST_W / 2;
  localparam logic signed [SW-1:0] ONE_S = SW'(1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_BLK, S_HERE, S_NB, S_OPEN, S_SQ, S_ROOT, S_EVAL,
    S_DONE, S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic [8:0] cfg_cols, cfg_rows;
  logic [7:0] goal_forward, goal_lateral;

  // walker and step working registers
  logic [COL_W-1:0]  walker_col, nb_col, best_col;
  logic [ROW_W-1:0]  walker_row, nb_row, best_row;
  logic [AW-1:0]     here_idx, nb_idx, clr_cnt;
  logic [2:0]        nb;
  logic [COST_W-1:0] g0, g_nb, best_g;
  logic [FW-1:0]     best_f;
  logic [RW-1:0]     best_h, h_nb;
  logic              found;
  logic [MW-1:0]     dxa, dya;

  // RAM ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata;

  // root unit
  logic             sq_start, sq_busy, sq_done;
  logic [RAD_W-1:0] sq_rad;
  logic [RW-1:0]    sq_root;

  // sizes in use and goal cell
  logic [UW-1:0]        wu, hu, half;
  logic signed [SW-1:0] gc_s, gr_s, half_s;

  always_comb begin
    if (cfg_cols == 9'd0) wu = UW'(1);
    else if (UW'(cfg_cols) > UW'(MAX_COLS)) wu = UW'(MAX_COLS);
    else wu = UW'(cfg_cols);
    if (cfg_rows == 9'd0) hu = UW'(1);
    else if (UW'(cfg_rows) > UW'(MAX_ROWS)) hu = UW'(MAX_ROWS);
    else hu = UW'(cfg_rows);
  end
  assign half   = wu >> 1;
  assign half_s = $signed(SW'(half));
  assign gc_s   = $signed({{(SW-8){goal_lateral[7]}}, goal_lateral}) + half_s;
  assign gr_s   = $signed(SW'(goal_forward));

  // input beat decode
  logic [UW-1:0] in_c, in_r;
  logic          in_ok, s_acc;
  logic [AW-1:0] in_idx, here_idx_c;
  assign s_acc  = s_tvalid && s_tready;
  assign in_c   = UW'(s_tdata[7:0]);
  assign in_r   = UW'(s_tdata[15:8]);
  assign in_ok  = (in_c < wu) && (in_r < hu);
  assign in_idx = AW'(AW'(in_r[ROW_W-1:0]) * AW'(MAX_COLS)) + AW'(in_c[COL_W-1:0]);
  assign here_idx_c = AW'(AW'(walker_row) * AW'(MAX_COLS)) + AW'(walker_col);

  // current neighbour position
  logic signed [1:0]    dc_v, dr_v;
  logic signed [SW-1:0] nc_s, nr_s;
  logic                 nb_in;
  logic [AW-1:0]        nb_idx_c;
  assign dc_v = nb_dc(nb);
  assign dr_v = nb_dr(nb);
  assign nc_s = $signed(SW'(walker_col)) + {{(SW-2){dc_v[1]}}, dc_v};
  assign nr_s = $signed(SW'(walker_row)) + {{(SW-2){dr_v[1]}}, dr_v};
  assign nb_in = !nc_s[SW-1] && !nr_s[SW-1] &&
                 (nc_s < $signed(SW'(wu))) && (nr_s < $signed(SW'(hu)));
  assign nb_idx_c = AW'(AW'(nr_s[ROW_W-1:0]) * AW'(MAX_COLS)) + AW'(nc_s[COL_W-1:0]);

  // neighbour cost and distance to goal
  logic signed [SW-1:0] dx_s, dy_s;
  logic [COST_W:0]      g_sum;
  logic [COST_W-1:0]    g_sat;
  assign dx_s  = gc_s - $signed(SW'(nb_col));
  assign dy_s  = gr_s - $signed(SW'(nb_row));
  assign g_sum = (COST_W+1)'(g0) +
                 (COST_W+1)'((dc_v != 2'sd0 && dr_v != 2'sd0) ?
                             STEP_DIAG : STEP_ONE);
  assign g_sat = g_sum[COST_W] ? COST_W'(COST_MAX) : g_sum[COST_W-1:0];

  // squared distance, shifted into fixed point
  logic [SQ_W-1:0] sq;
  assign sq       = SQ_W'(dxa) * SQ_W'(dxa) + SQ_W'(dya) * SQ_W'(dya);
  assign sq_rad   = RAD_W'(sq) << (2 * FRAC_BITS);
  assign sq_start = (state == S_SQ);

  // candidate ranking
  logic [FW-1:0] f_nb;
  logic          better;
  assign f_nb   = FW'(g_nb) + FW'(h_nb);
  assign better = !found || (f_nb < best_f) || (f_nb == best_f && h_nb < best_h);

  // result fields from the walker position
  logic signed [SW-1:0] pc_s, pr_s, rdx, rdy, lat_s;
  logic                 out_load;
  assign pc_s  = $signed(SW'(walker_col));
  assign pr_s  = $signed(SW'(walker_row));
  assign rdx   = gc_s - pc_s;
  assign rdy   = gr_s - pr_s;
  assign lat_s = pc_s - half_s;
  assign out_load = (state == S_OUT) && (!m_tvalid || m_tready);

  // RAM access control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = here_idx;
    ram_wdata = '0;
    ram_raddr = here_idx;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
      end
      S_IDLE: begin
        if (s_tuser == OP_BLOCK) ram_raddr = in_idx;
        else ram_raddr = here_idx_c;
      end
      S_BLK: begin
        ram_we    = 1'b1;
        ram_waddr = nb_idx;
        ram_wdata = {1'b1, ram_rdata[COST_W-1:0]};
      end
      S_NB: begin
        ram_raddr = nb_idx_c;
      end
      S_EVAL: begin
        ram_we    = 1'b1;
        ram_waddr = nb_idx;
        ram_wdata = {1'b0, g_nb};
      end
      S_DONE: begin
        ram_we    = found;
        ram_waddr = here_idx;
        ram_wdata = {1'b1, g0};
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      walker_col <= COL_W'(RST_HALF);
      walker_row <= '0;
      found      <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(CELLS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_acc) begin
            priority case (s_tuser)
              OP_BLOCK: begin
                nb_idx <= in_idx;
                if (in_ok) state <= S_BLK;
              end
              OP_STEP: begin
                here_idx <= here_idx_c;
                state    <= S_HERE;
              end
              OP_RESTART: begin
                clr_cnt    <= '0;
                walker_col <= half[COL_W-1:0];
                walker_row <= '0;
                state      <= S_CLEAR;
              end
              default: ;
            endcase
          end
        end
        S_BLK: state <= S_IDLE;
        S_HERE: begin
          g0    <= ram_rdata[COST_W-1:0];
          nb    <= '0;
          found <= 1'b0;
          state <= S_NB;
        end
        S_NB: begin
          nb_col <= nc_s[COL_W-1:0];
          nb_row <= nr_s[ROW_W-1:0];
          nb_idx <= nb_idx_c;
          if (nb_in) state <= S_OPEN;
          else if (nb == 3'd7) state <= S_DONE;
          else nb <= nb + 1'b1;
        end
        S_OPEN: begin
          dxa  <= dx_s[SW-1] ? MW'(-dx_s) : dx_s[MW-1:0];
          dya  <= dy_s[SW-1] ? MW'(-dy_s) : dy_s[MW-1:0];
          g_nb <= g_sat;
          if (!ram_rdata[DW-1]) state <= S_SQ;
          else if (nb == 3'd7) state <= S_DONE;
          else begin
            nb    <= nb + 1'b1;
            state <= S_NB;
          end
        end
        S_SQ: state <= S_ROOT;
        S_ROOT: begin
          if (sq_done) begin
            h_nb  <= sq_root;
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (better) begin
            found    <= 1'b1;
            best_f   <= f_nb;
            best_h   <= h_nb;
            best_g   <= g_nb;
            best_col <= nb_col;
            best_row <= nb_row;
          end
          if (nb == 3'd7) state <= S_DONE;
          else begin
            nb    <= nb + 1'b1;
            state <= S_NB;
          end
        end
        S_DONE: begin
          if (found) begin
            walker_col <= best_col;
            walker_row <= best_row;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            m_tdata[7:0]   <= lat_s[7:0];
            m_tdata[15:8]  <= pr_s[7:0];
            m_tdata[39:16] <= found ? best_g : g0;
            m_tdata[40]    <= (rdx >= -ONE_S) && (rdx <= ONE_S) &&
                              (rdy >= -ONE_S) && (rdy <= ONE_S);
            m_tdata[41]    <= !found;
            m_tdata[47:42] <= '0;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);

  // configuration port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_cols     <= COLS_RST;
      cfg_rows     <= ROWS_RST;
      goal_forward <= GOAL_FORWARD_RST;
      goal_lateral <= GOAL_LATERAL_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_COLS:         cfg_cols     <= pwdata[8:0];
        REG_ROWS:         cfg_rows     <= pwdata[8:0];
        REG_GOAL_FORWARD: goal_forward <= pwdata[7:0];
        REG_GOAL_LATERAL: goal_lateral <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_COLS:         prdata = 32'(cfg_cols);
      REG_ROWS:         prdata = 32'(cfg_rows);
      REG_GOAL_FORWARD: prdata = 32'(goal_forward);
      REG_GOAL_LATERAL: prdata = 32'(goal_lateral);
    endcase
  end

  // grid store: closed mark over path cost
  ggps_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared root unit for the goal distance
  ggps_isqrt #(.RAD_W(RAD_W)) u_root (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_rad),
    .busy     (sq_busy),
    .done     (sq_done),
    .root     (sq_root)
  );

  // checks
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_OUT))
    else $error("result beat raised outside the output stage");

  a_root_in_step: assert property (@(posedge clk) disable iff (rst)
    sq_busy |-> state == S_ROOT)
    else $error("root unit busy outside a neighbour evaluation");

  a_no_take_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !s_tready && ram_we)
    else $error("clearing pass stalled or open to input");

  a_dead_stays: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && !found |=> $stable(walker_col) && $stable(walker_row))
    else $error("walker moved on a dead end");

endmodule

`default_nettype wire

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the greedy grid path step block. Walks a directed
// table after reset, then a series of grid and goal settings with random
// blocks and steps. Every result beat is checked against the directed table or a
// cycle-free predictor of the walker and its grid store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import ggps_pkg::*;

  localparam int NCELL = 65536;
  localparam int CLEAR_WAIT = 66000;
  localparam int STEP_WAIT = 400;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [7:0]  lat;
    logic [7:0]  fwd;
    logic [23:0] cost;
    logic        arrived;
    logic        dead;
  } walk_res_t;

  typedef struct {
    op_t        op;
    logic [7:0] col;
    logic [7:0] row;
    bit         typed;
    walk_res_t  res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [7:0] cell_col, [15:8] cell_row
  logic [1:0]  s_tuser = '0;   // [1:0] op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;        // [7:0] pos_lateral, [15:8] pos_forward,
                               // [39:16] path_cost, [40] arrived, [41] dead_end
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  greedy_grid_path_step dut (.*);

  always #6 clk = ~clk;

  // predictor state
  bit          closed_map [NCELL];
  logic [23:0] cost_map [NCELL];
  int          walk_col, walk_row;
  int          cfg_w = 255, cfg_h = 256, cfg_gf = 12;
  logic [7:0]  cfg_gl = 8'd0;

  walk_res_t   pending_q [$];
  dir_row_t    dir_tab [$];
  int          fails = 0, cycles = 0, n_steps = 0, n_dead = 0, n_arrive = 0;
  bit          quiet = 0;
  int          long_hold = 0;
  op_t         last_op = OP_RESTART;

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, t;
    r = 0;
    for (int k = 31; k >= 0; k--) begin
      t = r | (64'd1 << k);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic int used_w();
    return (cfg_w < 1) ? 1 : (cfg_w > 256) ? 256 : cfg_w;
  endfunction

  function automatic int used_h();
    return (cfg_h < 1) ? 1 : (cfg_h > 256) ? 256 : cfg_h;
  endfunction

  function automatic void clear_grid();
    for (int i = 0; i < NCELL; i++) begin
      closed_map[i] = 0;
      cost_map[i] = '0;
    end
    walk_col = used_w() / 2;
    walk_row = 0;
  endfunction

  function automatic void add_row(dir_row_t row);
    dir_tab.insert(dir_tab.size(), row);
  endfunction

  // apply one input beat; returns 1 with the walker result for a step
  function automatic bit walk_predict(op_t op, int c_in, int r_in, output walk_res_t res);
    int w, h, half, gc, gr, bc, br, nc, nr, dx, dy, idx;
    longint unsigned g0, g, hh, f, bf, bh, diag;
    bit found;
    int dc [8] = '{-1, -1, 0, 1, 1, 1, 0, -1};
    int dr [8] = '{0, 1, 1, 1, 0, -1, -1, -1};
    w = used_w();
    h = used_h();
    half = w / 2;
    res = '0;
    if (op == OP_BLOCK) begin
      if (c_in < w && r_in < h) closed_map[c_in + r_in * 256] = 1;
      return 0;
    end
    if (op == OP_RESTART) begin
      clear_grid();
      return 0;
    end
    if (op != OP_STEP) return 0;
    gc = $signed(cfg_gl) + half;
    gr = cfg_gf;
    g0 = cost_map[(walk_col + walk_row * 256) % NCELL];
    diag = floor_root(64'd2 << 16);
    found = 0;
    bf = 0;
    bh = 0;
    bc = walk_col;
    br = walk_row;
    for (int i = 0; i < 8; i++) begin
      nc = walk_col + dc[i];
      nr = walk_row + dr[i];
      if (nc < 0 || nc >= w || nr < 0 || nr >= h) continue;
      idx = (nc + nr * 256) % NCELL;
      if (closed_map[idx]) continue;
      g = g0 + ((dc[i] != 0 && dr[i] != 0) ? diag : 256);
      if (g > COST_MAX) g = COST_MAX;
      dx = gc - nc;
      dy = gr - nr;
      hh = floor_root(longint'(dx * dx + dy * dy) << 16);
      f = g + hh;
      cost_map[idx] = g[23:0];
      if (!found || f < bf || (f == bf && hh < bh)) begin
        found = 1;
        bf = f;
        bh = hh;
        bc = nc;
        br = nr;
      end
    end
    if (found) begin
      closed_map[(walk_col + walk_row * 256) % NCELL] = 1;
      walk_col = bc;
      walk_row = br;
    end
    dx = gc - walk_col;
    dy = gr - walk_row;
    res.lat = 8'(walk_col - half);
    res.fwd = 8'(walk_row);
    res.cost = cost_map[(walk_col + walk_row * 256) % NCELL];
    res.arrived = (dx >= -1 && dx <= 1 && dy >= -1 && dy <= 1);
    res.dead = !found;
    return 1;
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    walk_res_t got, exp_r;
    if (!rst && m_tvalid && m_tready) begin
      got = walk_res_t'({m_tdata[7:0], m_tdata[15:8], m_tdata[39:16],
                         m_tdata[40], m_tdata[41]});
      if (pending_q.size() == 0) begin
        $error("result beat with nothing expected: %h", m_tdata);
        fails++;
      end else begin
        exp_r = pending_q.pop_front();
        if (got.lat !== exp_r.lat) begin
          $error("pos_lateral exp %0d got %0d", exp_r.lat, got.lat); fails++;
        end
        if (got.fwd !== exp_r.fwd) begin
          $error("pos_forward exp %0d got %0d", exp_r.fwd, got.fwd); fails++;
        end
        if (got.cost !== exp_r.cost) begin
          $error("path_cost exp %0d got %0d", exp_r.cost, got.cost); fails++;
        end
        if (got.arrived !== exp_r.arrived) begin
          $error("arrived exp %0d got %0d", exp_r.arrived, got.arrived); fails++;
        end
        if (got.dead !== exp_r.dead) begin
          $error("dead_end exp %0d got %0d", exp_r.dead, got.dead); fails++;
        end
        if (got.dead) n_dead++;
        if (got.arrived) n_arrive++;
      end
    end
  end

  // receiver: random stall bursts, one long hold on request
  initial begin
    int stall_left;
    logic nxt;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold > 0) begin
        long_hold--;
        nxt = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        nxt = 1'b0;
      end else begin
        nxt = 1'b1;
      end
      m_tready <= nxt;
    end
  end

  task automatic apb_write(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 4'(idx) << 2; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_COLS:         cfg_w = val[8:0];
      REG_ROWS:         cfg_h = val[8:0];
      REG_GOAL_FORWARD: cfg_gf = val[7:0];
      default:          cfg_gl = val[7:0];
    endcase
  endtask

  // offer one beat, wait for acceptance, then predict
  task automatic send_beat(op_t op, logic [7:0] c, logic [7:0] r, output walk_res_t res,
                           output bit has_res);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {r, c};
    do @(posedge clk); while (!s_tready);
    has_res = walk_predict(op, c, r, res);
    last_op = op;
    if (op == OP_STEP) n_steps++;
  endtask

  task automatic idle_line();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic drain();
    idle_line();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (last_op == OP_RESTART ? CLEAR_WAIT : STEP_WAIT) @(posedge clk);
  endtask

  // random item: mostly steps and blocks close to the walker
  task automatic random_beat();
    walk_res_t res;
    bit has;
    int k;
    op_t op;
    logic [7:0] c, r;
    k = $urandom_range(0, 99);
    c = 8'($urandom);
    r = 8'($urandom);
    if (k < 65) op = OP_STEP;
    else if (k < 92) begin
      op = OP_BLOCK;
      c = 8'(walk_col + $urandom_range(0, 4) - 2);
      r = 8'(walk_row + $urandom_range(0, 4) - 2);
    end else if (k < 97) op = OP_BLOCK;
    else op = OP_NONE;
    send_beat(op, c, r, res, has);
    if (has) pending_q.insert(pending_q.size(), res);
  endtask

  initial begin
    walk_res_t res;
    bit has;
    int setw [7] = '{255, 3, 256, 9, 0, 511, 17};
    int seth [7] = '{256, 2, 256, 8, 0, 300, 12};
    int setf [7] = '{12, 0, 255, 6, 200, 40, 11};
    int setl [7] = '{0, -128, 127, 3, -5, -100, -6};

    clear_grid();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table: reset settings, walker starts at (127,0), goal 12 ahead
    add_row('{OP_STEP, 8'd0, 8'd0, 1, '{8'd0, 8'd1, 24'd256, 1'b0, 1'b0}});
    add_row('{OP_STEP, 8'd0, 8'd0, 1, '{8'd0, 8'd2, 24'd512, 1'b0, 1'b0}});
    add_row('{OP_NONE, 8'hFF, 8'hFF, 0, '0});
    add_row('{OP_BLOCK, 8'd255, 8'd255, 0, '0});   // off the grid in use
    add_row('{OP_BLOCK, 8'd126, 8'd2, 0, '0});
    add_row('{OP_BLOCK, 8'd126, 8'd3, 0, '0});
    add_row('{OP_BLOCK, 8'd127, 8'd3, 0, '0});
    add_row('{OP_BLOCK, 8'd128, 8'd3, 0, '0});
    add_row('{OP_BLOCK, 8'd128, 8'd2, 0, '0});
    add_row('{OP_BLOCK, 8'd128, 8'd1, 0, '0});
    add_row('{OP_BLOCK, 8'd126, 8'd1, 0, '0});
    // boxed in: dead end keeps the stored cost
    add_row('{OP_STEP, 8'd0, 8'd0, 1, '{8'd0, 8'd2, 24'd512, 1'b0, 1'b1}});
    add_row('{OP_BLOCK, 8'd254, 8'd0, 0, '0});
    add_row('{OP_BLOCK, 8'd0, 8'd255, 0, '0});
    add_row('{OP_RESTART, 8'd0, 8'd0, 0, '0});
    add_row('{OP_STEP, 8'd0, 8'd0, 1, '{8'd0, 8'd1, 24'd256, 1'b0, 1'b0}});
    add_row('{OP_STEP, 8'd0, 8'd0, 0, '0});
    add_row('{OP_STEP, 8'd0, 8'd0, 0, '0});
    foreach (dir_tab[i]) begin
      send_beat(dir_tab[i].op, dir_tab[i].col, dir_tab[i].row, res, has);
      if (has) pending_q.insert(pending_q.size(), dir_tab[i].typed ? dir_tab[i].res : res);
    end

    // settings phases, random content
    for (int p = 0; p < 7; p++) begin
      drain();
      quiet = (p == 6);
      apb_write(REG_COLS, setw[p]);
      apb_write(REG_ROWS, seth[p]);
      apb_write(REG_GOAL_FORWARD, setf[p]);
      apb_write(REG_GOAL_LATERAL, 32'(8'(setl[p])));
      // phase 3 keeps the old walker on a shrunk grid for a while
      if (p != 3) begin
        send_beat(OP_RESTART, 8'd0, 8'd0, res, has);
      end
      for (int n = 0; n < 62; n++) begin
        if (p == 3 && n == 12) send_beat(OP_RESTART, 8'd0, 8'd0, res, has);
        if (p == 2 && n == 20) long_hold = 3000;
        if (p == 2 && n == 40) begin
          idle_line();
          while (pending_q.size() != 0) @(posedge clk);
        end
        random_beat();
      end
    end

    idle_line();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (STEP_WAIT) @(posedge clk);
    $display("covered %0d steps over 8 grid/goal settings: %0d dead ends, %0d arrivals",
             n_steps, n_dead, n_arrive);
    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
